### src/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg
// shared types and codes for the sstf request scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package sstf_pkg;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // request types
    localparam logic REQ_ADD      = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EVAL = 3'b010,
        ST_UPD  = 3'b100
    } seq_state_t;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic eval;      // compare stage: cells latch flags and picks
        logic add_upd;   // insert the new sector
        logic disp_upd;  // remove the entry at the cursor
        logic go_prev;   // cursor moves to the previous entry
        logic set_all;   // cursor back to entry zero
    } cell_ctl_t;

endpackage

`default_nettype wire

### src/sstf_cell.sv
// ----------------------------------------------------------------------------
// sstf_cell
// one slot of the sorted queue: holds a sector and the at-or-after-cursor flag
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_cell #(
    parameter int IDX         = 0,
    parameter int SECTOR_BITS = 48,
    parameter int CNT_W       = 6
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire sstf_pkg::cell_ctl_t    ctl,
    input  wire logic [CNT_W-1:0]       count,
    input  wire logic [SECTOR_BITS-1:0] new_sector,
    input  wire logic [SECTOR_BITS-1:0] left_sector,
    input  wire logic                   left_ge,
    input  wire logic                   left_le,
    input  wire logic [SECTOR_BITS-1:0] right_sector,
    input  wire logic                   right_ge,
    output logic [SECTOR_BITS-1:0]      sector_o,
    output logic                        ge_o,
    output logic                        le_o,
    output logic [SECTOR_BITS-1:0]      pick_o,
    output logic                        gop_o
);
    import sstf_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);
    localparam logic             FIRST  = (IDX == 0);

    logic [SECTOR_BITS-1:0] sector_reg, sector_next;
    logic                   ge_reg, ge_next;
    logic                   le_reg;
    logic [SECTOR_BITS-1:0] pick_reg;
    logic                   gop_reg;

    logic                   valid;
    logic                   right_valid;
    logic                   tok;
    logic [SECTOR_BITS-1:0] dp;
    logic [SECTOR_BITS-1:0] dn;
    logic                   go_prev_here;

    assign valid       = (IDX_C < count);
    assign right_valid = (NEXT_C < count);
    // the cursor sits where the flag first turns on
    assign tok         = ge_reg & (FIRST | ~left_ge);
    assign dp          = sector_reg - left_sector;
    assign dn          = right_sector - sector_reg;
    assign go_prev_here = ~FIRST & (~right_valid | (dp < dn));

    always_comb begin
        sector_next = sector_reg;
        ge_next     = ge_reg;
        if (ctl.add_upd) begin
            if (le_reg) begin
                sector_next = sector_reg;
            end else if (FIRST || left_le) begin
                sector_next = new_sector;
                ge_next     = FIRST ? 1'b0 : left_ge;
            end else begin
                sector_next = left_sector;
                ge_next     = left_ge;
            end
        end else if (ctl.disp_upd) begin
            if (ge_reg) begin
                sector_next = right_sector;
            end
            if (ctl.go_prev) begin
                ge_next = right_ge;
            end
        end
        if (ctl.set_all) begin
            ge_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ge_reg <= 1'b1;
            le_reg <= 1'b0;
        end else begin
            ge_reg <= ge_next;
            if (ctl.eval) begin
                le_reg <= valid & (sector_reg <= new_sector);
            end
        end
    end

    always_ff @(posedge aclk) begin
        sector_reg <= sector_next;
        if (ctl.eval) begin
            pick_reg <= tok ? sector_reg : '0;
            gop_reg  <= tok & go_prev_here;
        end
    end

    assign sector_o = sector_reg;
    assign ge_o     = ge_reg;
    assign le_o     = le_reg;
    assign pick_o   = pick_reg;
    assign gop_o    = gop_reg;

endmodule

`default_nettype wire

### src/sstf_request_scheduler_top.sv
// ----------------------------------------------------------------------------
// sstf_request_scheduler_top
// shortest-seek-time-first scheduler over a sorted chain of queue cells
// ----------------------------------------------------------------------------
// Input channel s_*: one item is either an add (s_req_type = 0, s_sector is
// inserted in sorted order after equal sectors) or a dispatch (s_req_type = 1,
// the sector at the cursor is returned and removed; the cursor then moves to
// the nearer neighbor, ties to the later one).
// Result channel m_*: exactly one result item per input item, carrying the
// dispatched sector, the dispatched flag, a status code and the queue count.
// Each item is handled in order: accept, a compare cycle in which every cell
// checks its sector against the new one and its neighbors, and an update
// cycle in which the chain shifts by one slot and the result is registered.
// The next item is taken the cycle after the update; no new item is
// accepted while one is still being compared or updated.
// The result register holds a finished item while the next one is accepted
// and evaluated; the update cycle waits only while that register is still
// full and m_ready is low.
// Reset (aresetn low, synchronous) empties the queue and puts the cursor on
// entry zero; the queue storage itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sstf_request_scheduler_top #(
    parameter int QUEUE_DEPTH = 32,
    parameter int SECTOR_BITS = 48
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_req_type,
    input  wire logic [SECTOR_BITS-1:0] s_sector,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [SECTOR_BITS-1:0]      m_out_sector,
    output logic                        m_dispatched,
    output logic [1:0]                  m_status,
    output logic [5:0]                  m_queue_count
);
    import sstf_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    seq_state_t state_reg, state_next;

    logic                   req_type_reg;
    logic [SECTOR_BITS-1:0] sector_in_reg;
    logic [CNT_W-1:0]       count_reg, count_next;

    logic                   m_valid_reg;
    logic [SECTOR_BITS-1:0] out_sector_reg;
    logic                   dispatched_reg;
    logic [1:0]             status_reg;
    logic [5:0]             queue_count_reg;

    logic [SECTOR_BITS-1:0] sec_w  [QUEUE_DEPTH];
    logic [SECTOR_BITS-1:0] pick_w [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] ge_w;
    logic [QUEUE_DEPTH-1:0] le_w;
    logic [QUEUE_DEPTH-1:0] gop_w;
    logic [QUEUE_DEPTH-1:0] tok_w;

    logic                   out_free;
    logic                   is_full;
    logic                   is_empty;
    logic                   do_add;
    logic                   do_disp;
    logic                   upd_fire;
    logic [SECTOR_BITS-1:0] pick_or;
    logic [1:0]             status_next;
    cell_ctl_t              ctl;

    assign out_free = ~m_valid_reg | m_ready;
    assign is_full  = (count_reg == DEPTH_C);
    assign is_empty = (count_reg == '0);
    assign upd_fire = (state_reg == ST_UPD) & out_free;
    assign do_add   = upd_fire & (req_type_reg == REQ_ADD) & ~is_full;
    assign do_disp  = upd_fire & (req_type_reg == REQ_DISPATCH) & ~is_empty;

    always_comb begin
        pick_or = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            pick_or = pick_or | pick_w[i];
        end
    end

    always_comb begin
        ctl.eval     = (state_reg == ST_EVAL);
        ctl.add_upd  = do_add;
        ctl.disp_upd = do_disp;
        ctl.go_prev  = |gop_w;
        // first add to an empty queue, or last entry dispatched
        ctl.set_all  = (do_add & is_empty) | (do_disp & (count_reg == ONE_C));
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (do_add) begin
            count_next = count_reg + ONE_C;
        end else if (do_disp) begin
            count_next = count_reg - ONE_C;
        end
    end

    always_comb begin
        status_next = STATUS_OK;
        if (req_type_reg == REQ_ADD) begin
            if (is_full) begin
                status_next = STATUS_FULL;
            end
        end else if (is_empty) begin
            status_next = STATUS_EMPTY;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (upd_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg  <= s_req_type;
            sector_in_reg <= s_sector;
        end
        if (upd_fire) begin
            out_sector_reg  <= do_disp ? pick_or : '0;
            dispatched_reg  <= do_disp;
            status_reg      <= status_next;
            queue_count_reg <= 6'(count_next);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_sector  = out_sector_reg;
    assign m_dispatched  = dispatched_reg;
    assign m_status      = status_reg;
    assign m_queue_count = queue_count_reg;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic [SECTOR_BITS-1:0] l_sec;
        logic                   l_ge;
        logic                   l_le;
        logic [SECTOR_BITS-1:0] r_sec;
        logic                   r_ge;

        if (g == 0) begin : g_first
            assign l_sec    = '0;
            assign l_ge     = 1'b0;
            assign l_le     = 1'b0;
            assign tok_w[g] = ge_w[g];
        end else begin : g_mid
            assign l_sec    = sec_w[g-1];
            assign l_ge     = ge_w[g-1];
            assign l_le     = le_w[g-1];
            assign tok_w[g] = ge_w[g] & ~ge_w[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign r_sec = sec_w[g];
            assign r_ge  = 1'b1;
        end else begin : g_inner
            assign r_sec = sec_w[g+1];
            assign r_ge  = ge_w[g+1];
        end

        sstf_cell #(
            .IDX         (g),
            .SECTOR_BITS (SECTOR_BITS),
            .CNT_W       (CNT_W)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .ctl          (ctl),
            .count        (count_reg),
            .new_sector   (sector_in_reg),
            .left_sector  (l_sec),
            .left_ge      (l_ge),
            .left_le      (l_le),
            .right_sector (r_sec),
            .right_ge     (r_ge),
            .sector_o     (sec_w[g]),
            .ge_o         (ge_w[g]),
            .le_o         (le_w[g]),
            .pick_o       (pick_w[g]),
            .gop_o        (gop_w[g])
        );
    end

    // exactly one cell carries the cursor
    a_one_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(tok_w))
        else $error("cursor token is not unique");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue count beyond depth");

    a_result_after_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        upd_fire |=> m_valid && m_queue_count == $past(6'(count_next)))
        else $error("result not registered after update");

    a_disp_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_dispatched |-> m_out_sector == '0)
        else $error("sector present without dispatch");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EVAL |-> !s_ready && $past(s_valid))
        else $error("evaluation without an accepted item");

endmodule

`default_nettype wire

### tb/sstf_request_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// sstf_request_scheduler_top_tb
// self-checking bench for the shortest-seek-time-first request scheduler
// ----------------------------------------------------------------------------
// A short table of hand-picked requests runs first: empty and full queue,
// sector extremes, equal sectors and equal seek distances. Random phases
// follow that fill, drain and churn the queue with clustered, extreme and
// wide sectors. Every accepted item is run through a sorted-queue predictor
// and each result is compared field by field in order. Both sides idle and
// stall at random.
// ----------------------------------------------------------------------------

module sstf_request_scheduler_top_tb;

    import sstf_pkg::*;

    localparam int DEPTH      = 32;
    localparam int SB         = 48;
    localparam int RAND_ITEMS = 386;
    localparam int IDLE_LIMIT = 2000;
    localparam int NROWS      = 21;

    localparam logic [SB-1:0] SECTOR_MAX = '1;

    typedef struct packed {
        logic [SB-1:0] out_sector;
        logic          dispatched;
        logic [1:0]    status;
        logic [5:0]    count;
    } sched_result_t;

    typedef struct packed {
        logic          req;
        logic [SB-1:0] sector;
        logic [5:0]    reps;
        logic [SB-1:0] stride;
        logic          fixed;
        sched_result_t want;
    } stim_row_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    logic          s_req_type = REQ_ADD;
    logic [SB-1:0] s_sector = '0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic [SB-1:0] m_out_sector;
    logic          m_dispatched;
    logic [1:0]    m_status;
    logic [5:0]    m_queue_count;

    // typed expectation that travels with the item on the input side
    logic          item_fixed = 1'b0;
    sched_result_t item_want = '0;

    // predictor state
    logic [SB-1:0] sorted_q [DEPTH];
    int            queued = 0;
    int            cursor = 0;

    sched_result_t awaited_replies [$];
    stim_row_t     stim_rows [NROWS];

    int mismatches = 0;
    int n_adds = 0;
    int n_dispatches = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_ties = 0;
    int peak_depth = 0;
    int idle_cycles = 0;
    bit no_gap = 1'b0;
    logic [SB-1:0] last_sector = '0;

    sstf_request_scheduler_top #(
        .QUEUE_DEPTH(DEPTH),
        .SECTOR_BITS(SB)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_sector     (s_sector),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sector (m_out_sector),
        .m_dispatched (m_dispatched),
        .m_status     (m_status),
        .m_queue_count(m_queue_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // sorted insert / nearest-neighbor dispatch, updates the predictor state
    function automatic sched_result_t predict_schedule(logic req, logic [SB-1:0] sec);
        sched_result_t r;
        int            pos;
        int            cur;
        int            i;
        logic          go_prev;
        logic [SB-1:0] d_lo;
        logic [SB-1:0] d_hi;
        r = '0;
        if (req == REQ_ADD) begin
            n_adds++;
            if (queued >= DEPTH) begin
                r.status = STATUS_FULL;
                n_full++;
            end else begin
                pos = 0;
                while (pos < queued && sorted_q[pos] <= sec) pos++;
                for (i = queued; i > pos; i--) sorted_q[i] = sorted_q[i-1];
                sorted_q[pos] = sec;
                if (queued == 0) cursor = 0;
                else if (pos <= cursor) cursor++;
                queued++;
                if (queued > peak_depth) peak_depth = queued;
            end
        end else begin
            n_dispatches++;
            if (queued == 0) begin
                r.status = STATUS_EMPTY;
                n_empty++;
            end else begin
                cur = (cursor >= queued) ? queued - 1 : cursor;
                r.out_sector = sorted_q[cur];
                r.dispatched = 1'b1;
                if (queued == 1 || cur == 0) begin
                    go_prev = 1'b0;
                end else if (cur == queued - 1) begin
                    go_prev = 1'b1;
                end else begin
                    d_lo = sorted_q[cur] - sorted_q[cur-1];
                    d_hi = sorted_q[cur+1] - sorted_q[cur];
                    go_prev = d_lo < d_hi;
                    if (d_lo == d_hi) n_ties++;
                end
                for (i = cur; i + 1 < queued; i++) sorted_q[i] = sorted_q[i+1];
                queued--;
                if (queued == 0) cursor = 0;
                else if (go_prev) cursor = cur - 1;
                else cursor = cur;
            end
        end
        r.count = 6'(queued);
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [SB-1:0] pick_sector();
        logic [SB-1:0] s;
        case ($urandom_range(0, 3))
            0: s = SB'({$urandom, $urandom});
            1: s = SB'($urandom_range(0, 31));
            2: begin
                case ($urandom_range(0, 3))
                    0: s = '0;
                    1: s = SB'(1);
                    2: s = SECTOR_MAX;
                    default: s = SECTOR_MAX - 1;
                endcase
            end
            default: s = last_sector + SB'($urandom_range(0, 8));
        endcase
        last_sector = s;
        return s;
    endfunction

    task automatic send_req(input logic req, input logic [SB-1:0] sec,
                            input logic fixed, input sched_result_t want);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_sector   <= sec;
        item_fixed <= fixed;
        item_want  <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // wait for an edge first so the item accepted at this edge is already queued
    task automatic drain_replies();
        @(posedge aclk);
        while (awaited_replies.size() != 0) @(posedge aclk);
    endtask

    // result side: ready stretches of random length, stalls of random length
    initial begin
        int on_len;
        int off_len;
        @(posedge aclk iff aresetn);
        forever begin
            on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                 : $urandom_range(1, 20);
            m_ready <= 1'b1;
            repeat (on_len) @(posedge aclk);
            off_len = pick_gap();
            if (off_len > 0) begin
                m_ready <= 1'b0;
                repeat (off_len) @(posedge aclk);
            end
        end
    end

    // prediction on every accepted item, in-order check of every result
    always @(posedge aclk) begin
        sched_result_t p;
        sched_result_t w;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                p = predict_schedule(s_req_type, s_sector);
                awaited_replies.push_back(item_fixed ? item_want : p);
            end
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    $error("result item with nothing pending: sector %h status %0d",
                           m_out_sector, m_status);
                    mismatches++;
                end else begin
                    w = awaited_replies.pop_front();
                    if (m_out_sector !== w.out_sector) begin
                        $error("out_sector expected %h got %h", w.out_sector, m_out_sector);
                        mismatches++;
                    end
                    if (m_dispatched !== w.dispatched) begin
                        $error("dispatched expected %0d got %0d", w.dispatched, m_dispatched);
                        mismatches++;
                    end
                    if (m_status !== w.status) begin
                        $error("status expected %0d got %0d", w.status, m_status);
                        mismatches++;
                    end
                    if (m_queue_count !== w.count) begin
                        $error("queue_count expected %0d got %0d", w.count, m_queue_count);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no handshake for %0d cycles", IDLE_LIMIT);
                $display("sstf_request_scheduler_top_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int            r;
        int            k;
        int            sent;
        int            phase_len;
        int            add_pct;
        logic          req;
        logic [SB-1:0] sec;

        stim_rows = '{
            '{REQ_DISPATCH, '0,         6'd1,  '0,     1'b1, '{'0, 1'b0, STATUS_EMPTY, 6'd0}},
            '{REQ_ADD,      '0,         6'd1,  '0,     1'b1, '{'0, 1'b0, STATUS_OK, 6'd1}},
            '{REQ_DISPATCH, SECTOR_MAX, 6'd1,  '0,     1'b1, '{'0, 1'b1, STATUS_OK, 6'd0}},
            '{REQ_ADD,      SECTOR_MAX, 6'd1,  '0,     1'b1, '{'0, 1'b0, STATUS_OK, 6'd1}},
            '{REQ_DISPATCH, '0,         6'd1,  '0,     1'b1,
              '{SECTOR_MAX, 1'b1, STATUS_OK, 6'd0}},
            '{REQ_DISPATCH, '0,         6'd1,  '0,     1'b1, '{'0, 1'b0, STATUS_EMPTY, 6'd0}},
            // 50 100 100 150 200 with the cursor on the first 100
            '{REQ_ADD,      SB'(100),   6'd1,  '0,     1'b0, '0},
            '{REQ_ADD,      SB'(50),    6'd1,  '0,     1'b0, '0},
            '{REQ_ADD,      SB'(150),   6'd1,  '0,     1'b0, '0},
            '{REQ_ADD,      SB'(100),   6'd1,  '0,     1'b0, '0},
            '{REQ_ADD,      SB'(200),   6'd1,  '0,     1'b0, '0},
            // zero distance to the equal sector, then a tie 50 / 50
            '{REQ_DISPATCH, '0,         6'd3,  '0,     1'b0, '0},
            '{REQ_ADD,      '0,         6'd1,  '0,     1'b0, '0},
            '{REQ_ADD,      SECTOR_MAX, 6'd1,  '0,     1'b0, '0},
            '{REQ_ADD,      SB'(120),   6'd1,  '0,     1'b0, '0},
            '{REQ_DISPATCH, SECTOR_MAX, 6'd8,  '0,     1'b0, '0},
            '{REQ_DISPATCH, '0,         6'd1,  '0,     1'b1, '{'0, 1'b0, STATUS_EMPTY, 6'd0}},
            '{REQ_ADD,      SB'(1000),  6'd32, SB'(7), 1'b0, '0},
            '{REQ_ADD,      SB'(5),     6'd1,  '0,     1'b1, '{'0, 1'b0, STATUS_FULL, 6'd32}},
            '{REQ_ADD,      SECTOR_MAX, 6'd1,  '0,     1'b1, '{'0, 1'b0, STATUS_FULL, 6'd32}},
            '{REQ_DISPATCH, '0,         6'd4,  '0,     1'b0, '0}
        };

        @(posedge aclk iff aresetn);

        for (r = 0; r < NROWS; r++) begin
            sec = stim_rows[r].sector;
            for (k = 0; k < int'(stim_rows[r].reps); k++) begin
                send_req(stim_rows[r].req, sec, stim_rows[r].fixed, stim_rows[r].want);
                sec = sec + stim_rows[r].stride;
            end
        end

        // hold off until the block has answered everything
        s_valid <= 1'b0;
        drain_replies();

        sent = 0;
        while (sent < RAND_ITEMS) begin
            phase_len = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0: add_pct = 85;
                1: add_pct = 15;
                default: add_pct = 50;
            endcase
            no_gap = ($urandom_range(0, 5) == 0);
            for (k = 0; k < phase_len && sent < RAND_ITEMS; k++) begin
                req = ($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_DISPATCH;
                send_req(req, pick_sector(), 1'b0, '0);
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                drain_replies();
            end
        end

        s_valid <= 1'b0;
        drain_replies();
        repeat (10) @(posedge aclk);

        $display("covered %0d adds (%0d dropped on a full queue), %0d dispatches (%0d on empty)",
                 n_adds, n_full, n_dispatches, n_empty);
        $display("deepest queue %0d, %0d equal-distance neighbor choices, %0d mismatches",
                 peak_depth, n_ties, mismatches);
        if (mismatches == 0 && awaited_replies.size() == 0) begin
            $display("sstf_request_scheduler_top_tb: PASS");
        end else begin
            $display("sstf_request_scheduler_top_tb: FAIL");
        end
        $finish;
    end

endmodule

### files.f
src/sstf_pkg.sv
src/sstf_cell.sv
src/sstf_request_scheduler_top.sv
tb/sstf_request_scheduler_top_tb.sv
